// File: rtl/rle_pkg.sv
`timescale 1ns / 1ps
// rle_pkg: shared types, constants and helper functions of the run-length item encoder
// no dependencies; used by every other file of the block except rle_ifs

package rle_pkg;

  localparam logic [16:0] MAX_RUN_ITEMS      = 17'd65535;
  localparam logic [16:0] ITEMS_CAP          = 17'h1FFFF;
  localparam logic [23:0] ENVELOPE_BYTES     = 24'd48;
  localparam logic [2:0]  LENGTH_FIELD_BYTES = 3'd2;
  localparam int          CFG_ADDR_W         = 5;
  localparam int          CFG_DATA_W         = 32;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_OVERFLOW   = 2'd1,
    STATUS_BAD_SAMPLE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_ITEM_WIDTH   = 3'd0,
    REG_ITEM_LIMIT   = 3'd1,
    REG_FRAME_BUDGET = 3'd2,
    REG_SAMPLE_EN    = 3'd3,
    REG_CODE_BITS    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  item_width_bytes;
    logic [15:0] item_limit;
    logic [23:0] frame_byte_budget;
    logic        sample_check_enable;
    logic [4:0]  sample_code_bits;
  } cfg_t;

  // one queued command: an optional finished run plus an optional final word
  typedef struct packed {
    logic        has_rec;
    logic [15:0] rec_len;
    logic [31:0] rec_val;
    logic        fin;
    status_t     status;
    logic [15:0] fin_len;
    logic [31:0] fin_val;
    logic [15:0] runs;
  } cmd_t;

  function automatic logic [2:0] eff_width(input logic [2:0] w);
    logic [2:0] r;
    if (w == 3'd0) r = 3'd1;
    else if (w > 3'd4) r = 3'd4;
    else r = w;
    return r;
  endfunction

  function automatic logic [31:0] width_mask(input logic [2:0] w);
    logic [31:0] m;
    case (w)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/rle_ifs.sv
`timescale 1ns / 1ps
// rle_in_if / rle_out_if: valid-ready channels of the run-length item encoder
// no dependencies

interface rle_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] item_value;
  logic        last_item;

  modport source (output valid, output item_value, output last_item, input ready);
  modport sink   (input valid, input item_value, input last_item, output ready);
endinterface

interface rle_out_if;
  logic        valid;
  logic        ready;
  logic        record_valid;
  logic [15:0] run_len;
  logic [31:0] run_value;
  logic        final_result;
  logic [15:0] runs_total;
  logic [18:0] payload_size;
  logic        encode_chosen;
  logic [1:0]  result_status;

  modport source (output valid, output record_valid, output run_len, output run_value,
                  output final_result, output runs_total, output payload_size,
                  output encode_chosen, output result_status, input ready);
  modport sink   (input valid, input record_valid, input run_len, input run_value,
                  input final_result, input runs_total, input payload_size,
                  input encode_chosen, input result_status, output ready);
endinterface

// File: rtl/rle_regs.sv
`timescale 1ns / 1ps
// rle_regs: apb-style configuration registers of the run-length item encoder
// depends on rle_pkg

module rle_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rle_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rle_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rle_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output rle_pkg::cfg_t                    cfg
);

  rle_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        rle_pkg::REG_ITEM_WIDTH:   cfg_nxt.item_width_bytes    = pwdata[2:0];
        rle_pkg::REG_ITEM_LIMIT:   cfg_nxt.item_limit          = pwdata[15:0];
        rle_pkg::REG_FRAME_BUDGET: cfg_nxt.frame_byte_budget   = pwdata[23:0];
        rle_pkg::REG_SAMPLE_EN:    cfg_nxt.sample_check_enable = pwdata[0];
        rle_pkg::REG_CODE_BITS:    cfg_nxt.sample_code_bits    = pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rle_pkg::REG_ITEM_WIDTH:   prdata = 32'(cfg_r.item_width_bytes);
      rle_pkg::REG_ITEM_LIMIT:   prdata = 32'(cfg_r.item_limit);
      rle_pkg::REG_FRAME_BUDGET: prdata = 32'(cfg_r.frame_byte_budget);
      rle_pkg::REG_SAMPLE_EN:    prdata = 32'(cfg_r.sample_check_enable);
      rle_pkg::REG_CODE_BITS:    prdata = 32'(cfg_r.sample_code_bits);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.item_width_bytes    <= 3'd1;
      cfg_r.item_limit          <= 16'd65535;
      cfg_r.frame_byte_budget   <= 24'd4096;
      cfg_r.sample_check_enable <= 1'b0;
      cfg_r.sample_code_bits    <= 5'd12;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/rle_front.sv
`timescale 1ns / 1ps
// rle_front: accepts items, masks and checks them, tracks the open run and
// queues one command per item that finishes a run or closes the buffer; depends on rle_pkg, rle_in_if

module rle_front (
  input  logic               clk,
  input  logic               rst_n,
  rle_in_if.sink             in_ch,
  input  rle_pkg::cfg_t      cfg,
  input  logic               q_full,
  output logic               q_push,
  output rle_pkg::cmd_t      q_data
);

  logic [31:0]      held_value_r, held_value_nxt;
  logic [15:0]      held_length_r, held_length_nxt;
  logic [16:0]      items_seen_r, items_seen_nxt;
  logic [15:0]      runs_seen_r, runs_seen_nxt;
  logic             have_item_r, have_item_nxt;
  rle_pkg::status_t error_r, error_nxt;

  logic             fire;
  logic [2:0]       w;
  logic [31:0]      v;
  logic [16:0]      items_inc;
  logic             overflow;
  logic [15:0]      code_mask;
  logic [15:0]      bad_bits;
  logic             sample_bad;
  rle_pkg::status_t status;
  rle_pkg::cmd_t    cmd;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && !q_full;

  always_comb begin
    w         = rle_pkg::eff_width(cfg.item_width_bytes);
    v         = in_ch.item_value & rle_pkg::width_mask(w);
    items_inc = (items_seen_r != rle_pkg::ITEMS_CAP) ? items_seen_r + 17'd1 : items_seen_r;
    overflow  = (items_inc > {1'b0, cfg.item_limit}) || (items_inc > rle_pkg::MAX_RUN_ITEMS);
    code_mask = (cfg.sample_code_bits >= 5'd16) ? 16'hFFFF
              : 16'((17'd1 << cfg.sample_code_bits) - 17'd1);
    bad_bits  = ~code_mask;
    sample_bad = ((v[15:0] & bad_bits) != 16'd0) || ((v[31:16] & bad_bits) != 16'd0);

    status = error_r;
    if (overflow) begin
      status = rle_pkg::STATUS_OVERFLOW;
    end else if (cfg.sample_check_enable && (w == 3'd4) && sample_bad &&
                 (status == rle_pkg::STATUS_OK)) begin
      status = rle_pkg::STATUS_BAD_SAMPLE;
    end

    held_value_nxt  = held_value_r;
    held_length_nxt = held_length_r;
    runs_seen_nxt   = runs_seen_r;
    have_item_nxt   = have_item_r;
    items_seen_nxt  = items_seen_r;
    error_nxt       = error_r;

    cmd         = '0;
    cmd.rec_len = held_length_r;
    cmd.rec_val = held_value_r;

    if (status == rle_pkg::STATUS_OK) begin
      if (have_item_r && (v == held_value_r)) begin
        held_length_nxt = held_length_r + 16'd1;
      end else begin
        cmd.has_rec     = have_item_r;
        runs_seen_nxt   = runs_seen_r + 16'd1;
        held_value_nxt  = v;
        held_length_nxt = 16'd1;
        have_item_nxt   = 1'b1;
      end
    end

    cmd.fin     = in_ch.last_item;
    cmd.status  = status;
    cmd.fin_len = held_length_nxt;
    cmd.fin_val = held_value_nxt;
    cmd.runs    = runs_seen_nxt;

    items_seen_nxt = items_inc;
    error_nxt      = status;

    // buffer closed: start over
    if (in_ch.last_item) begin
      held_value_nxt  = '0;
      held_length_nxt = '0;
      runs_seen_nxt   = '0;
      have_item_nxt   = 1'b0;
      items_seen_nxt  = '0;
      error_nxt       = rle_pkg::STATUS_OK;
    end
  end

  assign q_push = fire && (cmd.has_rec || cmd.fin);
  assign q_data = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_value_r  <= '0;
      held_length_r <= '0;
      items_seen_r  <= '0;
      runs_seen_r   <= '0;
      have_item_r   <= 1'b0;
      error_r       <= rle_pkg::STATUS_OK;
    end else if (fire) begin
      held_value_r  <= held_value_nxt;
      held_length_r <= held_length_nxt;
      items_seen_r  <= items_seen_nxt;
      runs_seen_r   <= runs_seen_nxt;
      have_item_r   <= have_item_nxt;
      error_r       <= error_nxt;
    end
  end

endmodule

// File: rtl/rle_queue.sv
`timescale 1ns / 1ps
// rle_queue: small command fifo between front and back of the encoder
// depends on rle_pkg

module rle_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rle_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output rle_pkg::cmd_t head,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  rle_pkg::cmd_t    slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: rtl/rle_back.sv
`timescale 1ns / 1ps
// rle_back: expands queued commands into result words, computes the payload
// size and budget decision, holds the output register; depends on rle_pkg, rle_out_if

module rle_back (
  input  logic          clk,
  input  logic          rst_n,
  input  rle_pkg::cfg_t cfg,
  input  rle_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          q_pop,
  rle_out_if.source     out_ch
);

  typedef struct packed {
    logic        record_valid;
    logic [15:0] run_len;
    logic [31:0] run_value;
    logic        final_result;
    logic [15:0] runs_total;
    logic [18:0] payload_size;
    logic        encode_chosen;
    logic [1:0]  result_status;
  } word_t;

  logic          out_valid_r, out_valid_nxt;
  word_t         word_r, word_nxt;
  logic          pend_r, pend_nxt;
  rle_pkg::cmd_t pend_cmd_r, pend_cmd_nxt;

  rle_pkg::cmd_t src;
  logic          load;
  logic [2:0]    w;
  logic [2:0]    bytes_per_run;
  logic [18:0]   pay;
  logic          chosen;
  word_t         fin_word;
  word_t         rec_word;

  assign load  = !out_valid_r || out_ch.ready;
  assign q_pop = load && !pend_r && !q_empty;
  assign src   = pend_r ? pend_cmd_r : head;

  always_comb begin
    w             = rle_pkg::eff_width(cfg.item_width_bytes);
    bytes_per_run = w + rle_pkg::LENGTH_FIELD_BYTES;
    pay           = 19'(src.runs) * 19'(bytes_per_run);
    chosen        = (24'(pay) + rle_pkg::ENVELOPE_BYTES) <= cfg.frame_byte_budget;

    fin_word              = '0;
    fin_word.final_result = 1'b1;
    fin_word.result_status = src.status;
    if (src.status == rle_pkg::STATUS_OK) begin
      fin_word.record_valid  = 1'b1;
      fin_word.run_len       = src.fin_len;
      fin_word.run_value     = src.fin_val;
      fin_word.runs_total    = src.runs;
      fin_word.payload_size  = pay;
      fin_word.encode_chosen = chosen;
    end

    rec_word              = '0;
    rec_word.record_valid = 1'b1;
    rec_word.run_len      = src.rec_len;
    rec_word.run_value    = src.rec_val;

    out_valid_nxt = out_valid_r;
    word_nxt      = word_r;
    pend_nxt      = pend_r;
    pend_cmd_nxt  = pend_cmd_r;
    if (load) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        word_nxt      = fin_word;
        pend_nxt      = 1'b0;
      end else if (!q_empty) begin
        out_valid_nxt = 1'b1;
        if (head.has_rec) begin
          word_nxt     = rec_word;
          pend_nxt     = head.fin;
          pend_cmd_nxt = head;
        end else begin
          word_nxt = fin_word;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
    word_r     <= word_nxt;
    pend_cmd_r <= pend_cmd_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.record_valid  = word_r.record_valid;
  assign out_ch.run_len       = word_r.run_len;
  assign out_ch.run_value     = word_r.run_value;
  assign out_ch.final_result  = word_r.final_result;
  assign out_ch.runs_total    = word_r.runs_total;
  assign out_ch.payload_size  = word_r.payload_size;
  assign out_ch.encode_chosen = word_r.encode_chosen;
  assign out_ch.result_status = word_r.result_status;

endmodule

// File: rtl/run_length_item_encoder.sv
`timescale 1ns / 1ps
// run_length_item_encoder: run-length encoder for one buffer of fixed-width items
// depends on rle_pkg, rle_ifs, rle_regs, rle_front, rle_queue, rle_back
//
// usage
//   in_ch carries one item word per handshake (item_value, last_item); items of a
//   buffer stream in order, last_item closes the buffer
//   out_ch carries result words: one record per finished run, and a final word
//   with run count, payload size, budget decision and status at buffer end
//   the apb-style port sets width, item limit, frame budget and the sample check;
//   write it only while no buffer is in flight
// timing
//   one item per cycle while the command queue is not full; the front updates the open run
//   in the accept cycle and queues a command, which the back takes from the queue head
//   and registers as a result word in the output register when the output is free
//   a last item that also finishes a run gives two words, one per cycle while out_ch is ready
//   the command queue holds QUEUE_DEPTH entries
// reset and stall
//   synchronous reset clears the run state, the queue and the output valid flag and
//   restores register defaults; no clearing pass is needed
//   when out_ch stalls the output word holds, the queue fills, then in_ch.ready drops

module run_length_item_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rle_in_if.sink                         in_ch,
  rle_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rle_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rle_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rle_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  rle_pkg::cfg_t cfg;
  rle_pkg::cmd_t q_data;
  rle_pkg::cmd_t q_head;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;

  rle_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rle_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  rle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  rle_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: rtl/rle_checker.sv
`timescale 1ns / 1ps
// rle_port_checker: port-level checks of the run-length item encoder results
// bound to run_length_item_encoder; depends on rle_pkg and on rle_ifs through the bind

module rle_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        record_valid,
  input logic [15:0] run_len,
  input logic [31:0] run_value,
  input logic        final_result,
  input logic [15:0] runs_total,
  input logic [18:0] payload_size,
  input logic        encode_chosen,
  input logic [1:0]  result_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(run_value) && $stable(final_result))
    else $error("result word dropped or changed while stalled");

  a_no_record_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !record_valid |-> run_len == 16'd0 && run_value == 32'd0)
    else $error("run fields set without a record");

  a_mid_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !final_result |-> record_valid && runs_total == 16'd0 &&
      payload_size == 19'd0 && !encode_chosen && result_status == rle_pkg::STATUS_OK)
    else $error("non-final word carries summary fields");

  a_error_no_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && final_result && result_status != rle_pkg::STATUS_OK |->
      !record_valid && runs_total == 16'd0 && !encode_chosen && payload_size == 19'd0)
    else $error("error word carries a record or summary");

  a_run_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && record_valid |-> run_len != 16'd0 || final_result == 1'b0)
    else $error("final record with zero run length");

endmodule

bind run_length_item_encoder rle_port_checker u_rle_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .record_valid  (out_ch.record_valid),
  .run_len       (out_ch.run_len),
  .run_value     (out_ch.run_value),
  .final_result  (out_ch.final_result),
  .runs_total    (out_ch.runs_total),
  .payload_size  (out_ch.payload_size),
  .encode_chosen (out_ch.encode_chosen),
  .result_status (out_ch.result_status)
);

// File: bench/rle_checker.sv
`timescale 1ns / 1ps
// rle_checker: watches the item, result and register ports of the run-length item encoder,
// keeps its own run state and register copy, predicts each result word and compares it
// depends on rle_pkg and the rle_in_if / rle_out_if interfaces

module rle_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  rle_in_if                              in_mon,
  rle_out_if                             out_mon,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [rle_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rle_pkg::CFG_DATA_W-1:0] pwdata,
  output int                             pending_results,
  output int                             failures
);

  typedef struct packed {
    logic             rec;
    logic [15:0]      len;
    logic [31:0]      val;
    logic             fin;
    logic [15:0]      runs;
    logic [18:0]      pay;
    logic             chosen;
    rle_pkg::status_t status;
  } enc_word_t;

  logic [2:0]  width_reg;
  logic [15:0] limit_reg;
  logic [23:0] budget_reg;
  logic        check_en;
  logic [4:0]  code_bits;

  logic [31:0]      held_value;
  logic [15:0]      held_length;
  logic [16:0]      items_taken;
  logic [15:0]      runs_counted;
  logic             run_open;
  rle_pkg::status_t buf_status;

  enc_word_t   expected_words[$];
  enc_word_t   want;
  int          mismatch_total;

  function automatic void clear_run_state();
    held_value   = '0;
    held_length  = '0;
    items_taken  = '0;
    runs_counted = '0;
    run_open     = 1'b0;
    buf_status   = rle_pkg::STATUS_OK;
  endfunction

  function automatic void encode_item(input logic [31:0] raw, input logic last);
    logic [2:0]  w;
    logic [31:0] keep;
    logic [31:0] v;
    logic [15:0] code_ok;
    logic [31:0] bad_bits;
    enc_word_t   word;
    int          pay;
    w = (width_reg == 3'd0) ? 3'd1 : (width_reg > 3'd4) ? 3'd4 : width_reg;
    keep = (w == 3'd4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * w)) - 32'h1);
    v = raw & keep;
    if (items_taken != rle_pkg::ITEMS_CAP) items_taken++;
    if (items_taken > {1'b0, limit_reg} || items_taken > rle_pkg::MAX_RUN_ITEMS)
      buf_status = rle_pkg::STATUS_OVERFLOW;
    code_ok = (code_bits >= 5'd16) ? 16'hFFFF : ((16'h1 << code_bits) - 16'h1);
    bad_bits = {~code_ok, ~code_ok};
    if (check_en && w == 3'd4 && (v & bad_bits) != 32'd0 &&
        buf_status == rle_pkg::STATUS_OK)
      buf_status = rle_pkg::STATUS_BAD_SAMPLE;
    if (buf_status == rle_pkg::STATUS_OK) begin
      if (run_open && v == held_value) begin
        held_length++;
      end else begin
        if (run_open) begin
          word = '0;
          word.rec = 1'b1;
          word.len = held_length;
          word.val = held_value;
          expected_words.push_back(word);
        end
        runs_counted++;
        held_value  = v;
        held_length = 16'd1;
        run_open    = 1'b1;
      end
    end
    if (last) begin
      word = '0;
      word.fin = 1'b1;
      if (buf_status == rle_pkg::STATUS_OK) begin
        pay = int'(runs_counted) * (int'(w) + int'(rle_pkg::LENGTH_FIELD_BYTES));
        word.rec    = 1'b1;
        word.len    = held_length;
        word.val    = held_value;
        word.runs   = runs_counted;
        word.pay    = 19'(pay);
        word.chosen = (int'(rle_pkg::ENVELOPE_BYTES) + pay) <= int'(budget_reg);
      end else begin
        word.status = buf_status;
      end
      expected_words.push_back(word);
      clear_run_state();
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = 3'd1;
      limit_reg  = 16'd65535;
      budget_reg = 24'd4096;
      check_en   = 1'b0;
      code_bits  = 5'd12;
      clear_run_state();
      expected_words.delete();
      mismatch_total = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (rle_pkg::reg_idx_t'(paddr[rle_pkg::CFG_ADDR_W-1:2]))
          rle_pkg::REG_ITEM_WIDTH:   width_reg  = pwdata[2:0];
          rle_pkg::REG_ITEM_LIMIT:   limit_reg  = pwdata[15:0];
          rle_pkg::REG_FRAME_BUDGET: budget_reg = pwdata[23:0];
          rle_pkg::REG_SAMPLE_EN:    check_en   = pwdata[0];
          rle_pkg::REG_CODE_BITS:    code_bits  = pwdata[4:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          mismatch_total++;
        end else begin
          want = expected_words.pop_front();
          check_field("record_valid", 32'(want.rec), 32'(out_mon.record_valid));
          check_field("run_len", 32'(want.len), 32'(out_mon.run_len));
          check_field("run_value", want.val, out_mon.run_value);
          check_field("final_result", 32'(want.fin), 32'(out_mon.final_result));
          check_field("runs_total", 32'(want.runs), 32'(out_mon.runs_total));
          check_field("payload_size", 32'(want.pay), 32'(out_mon.payload_size));
          check_field("encode_chosen", 32'(want.chosen), 32'(out_mon.encode_chosen));
          check_field("result_status", 32'(want.status), 32'(out_mon.result_status));
        end
      end
      if (in_mon.valid && in_mon.ready)
        encode_item(in_mon.item_value, in_mon.last_item);
    end
    pending_results <= expected_words.size();
    failures <= mismatch_total;
  end

endmodule

// File: bench/tb_run_length_item_encoder.sv
`timescale 1ns / 1ps
// tb_run_length_item_encoder: clock, reset, register writes and item stimulus for the
// run-length item encoder, with a bursty sender and a stalling receiver; verdict from rle_checker
// depends on rle_pkg, rle_ifs, run_length_item_encoder and rle_checker

module tb_run_length_item_encoder;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  logic                           clk;
  logic                           rst_n;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [rle_pkg::CFG_ADDR_W-1:0] paddr;
  logic [rle_pkg::CFG_DATA_W-1:0] pwdata;
  logic [rle_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  rle_in_if  in_ch ();
  rle_out_if out_ch ();

  int          pending_results;
  int          failures;
  int unsigned cycle_count = 0;
  int          burst_left;
  logic [31:0] prev_value;
  int unsigned cur_width;
  int unsigned cur_check;
  int unsigned cur_bits;

  run_length_item_encoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rle_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pending_results (pending_results),
    .failures        (failures)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run_length_item_encoder regression: fail");
      $finish;
    end
  end

  // receiver stall pattern
  initial begin
    int unsigned rx_cycle;
    rx_cycle = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      case ((rx_cycle / 256) % 4)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 9) < 7);
        2:       out_ch.ready <= ($urandom_range(0, 9) < 3);
        default: out_ch.ready <= ((rx_cycle % 11) < 4);
      endcase
    end
  end

  task automatic write_reg(input rle_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == rle_pkg::REG_ITEM_WIDTH) cur_width = 32'(value[2:0]);
    if (idx == rle_pkg::REG_SAMPLE_EN) cur_check = 32'(value[0]);
    if (idx == rle_pkg::REG_CODE_BITS) cur_bits = 32'(value[4:0]);
  endtask

  task automatic set_config(input int unsigned w, input int unsigned lim,
                            input int unsigned bud, input int unsigned en,
                            input int unsigned bits);
    write_reg(rle_pkg::REG_ITEM_WIDTH, w);
    write_reg(rle_pkg::REG_ITEM_LIMIT, lim);
    write_reg(rle_pkg::REG_FRAME_BUDGET, bud);
    write_reg(rle_pkg::REG_SAMPLE_EN, en);
    write_reg(rle_pkg::REG_CODE_BITS, bits);
  endtask

  // sender stops and waits until every expected word is back
  task automatic drain(input int extra);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic send_item(input logic [31:0] value, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.item_value <= value;
    in_ch.last_item  <= last;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    logic [31:0] keep;
    logic [15:0] code_ok;
    int unsigned ew;
    int unsigned roll;
    ew = (cur_width == 0) ? 1 : (cur_width > 4) ? 4 : cur_width;
    keep = (ew == 4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * ew)) - 32'h1);
    roll = $urandom_range(0, 99);
    if (roll < 45) v = (prev_value & keep) | ($urandom() & ~keep);
    else if (roll < 60) v = $urandom();
    else if (roll < 80) v = $urandom_range(0, 3);
    else v = $urandom() & keep;
    if (cur_check != 0 && ew == 4 && $urandom_range(0, 9) != 0) begin
      code_ok = (cur_bits >= 16) ? 16'hFFFF : ((16'h1 << cur_bits) - 16'h1);
      v = v & {code_ok, code_ok};
    end
    prev_value = v;
    return v;
  endfunction

  initial begin
    int          phase;
    int          sent;
    int          len;
    int          k;
    int unsigned lim;
    int unsigned bud;
    logic        paused;
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.item_value = '0;
    in_ch.last_item  = 1'b0;
    burst_left       = 0;
    prev_value       = '0;
    cur_width        = 1;
    cur_check        = 0;
    cur_bits         = 12;
    paused           = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words
    set_config(4, 65535, 4096, 0, 12);
    send_item(32'hFFFF_FFFF, 1'b1);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    drain(4);
    write_reg(rle_pkg::REG_ITEM_WIDTH, 0);
    send_item(32'h1234_56AB, 1'b0);
    send_item(32'h0000_00AB, 1'b1);
    drain(4);
    write_reg(rle_pkg::REG_ITEM_WIDTH, 7);
    send_item(32'h8000_0001, 1'b1);
    drain(4);
    set_config(2, 65535, 0, 0, 12);
    send_item(32'h0001_FFFF, 1'b0);
    send_item(32'h0000_FFFF, 1'b1);
    drain(4);
    set_config(3, 65535, 58, 0, 12);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h0000_0002, 1'b1);
    drain(4);
    write_reg(rle_pkg::REG_ITEM_LIMIT, 0);
    send_item(32'h0000_0005, 1'b1);
    drain(4);
    write_reg(rle_pkg::REG_ITEM_LIMIT, 2);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h0000_0002, 1'b0);
    send_item(32'h0000_0003, 1'b1);
    drain(4);
    set_config(4, 65535, 4096, 1, 12);
    send_item(32'h0FFF_0FFF, 1'b0);
    send_item(32'h1000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b1);
    send_item(32'h0000_1000, 1'b1);
    drain(4);
    write_reg(rle_pkg::REG_CODE_BITS, 0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0000_0001, 1'b1);
    drain(4);
    write_reg(rle_pkg::REG_CODE_BITS, 16);
    send_item(32'hFFFF_FFFF, 1'b1);
    drain(4);
    write_reg(rle_pkg::REG_CODE_BITS, 31);
    send_item(32'hFFFF_FFFF, 1'b1);
    drain(4);
    write_reg(rle_pkg::REG_ITEM_LIMIT, 1);
    write_reg(rle_pkg::REG_CODE_BITS, 12);
    send_item(32'hF000_F000, 1'b0);
    send_item(32'h0000_0005, 1'b1);
    drain(4);
    set_config(2, 65535, 4096, 1, 0);
    send_item(32'h0000_FFFF, 1'b1);
    drain(4);
    // width change inside an open buffer
    set_config(4, 65535, 4096, 0, 12);
    send_item(32'h0000_01FF, 1'b0);
    drain(4);
    write_reg(rle_pkg::REG_ITEM_WIDTH, 1);
    send_item(32'h0000_00FF, 1'b1);

    // random buffers
    for (phase = 0; phase < 12; phase++) begin
      drain(4);
      case ($urandom_range(0, 9))
        0:       lim = 0;
        1:       lim = 1;
        2, 3:    lim = $urandom_range(2, 40);
        default: lim = 65535;
      endcase
      case ($urandom_range(0, 3))
        0:       bud = 0;
        1:       bud = 24'hFF_FFFF;
        2:       bud = $urandom_range(48, 160);
        default: bud = $urandom_range(0, 24'hFF_FFFF);
      endcase
      set_config($urandom_range(0, 7), lim, bud, $urandom_range(0, 1),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(8, 16));
      sent = 0;
      while (sent < 104) begin
        k = $urandom_range(0, 19);
        len = (k < 14) ? $urandom_range(1, 12) : (k < 18) ? $urandom_range(13, 40) : 1;
        for (k = 0; k < len; k++)
          send_item(pick_value(), k == len - 1);
        sent += len;
        if (phase == 6 && sent > 50 && !paused) begin
          paused = 1'b1;
          drain(0);
        end
      end
    end

    drain(16);
    if (failures == 0 && pending_results == 0) begin
      $display("run_length_item_encoder regression: pass");
    end else begin
      $display("run_length_item_encoder regression: fail");
    end
    $finish;
  end

endmodule
